/* src/assert_macros.svh */
// Assertion macros shared by the odometry RTL.
// Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* src/ddo_pkg.sv */
// Package for the differential drive odometry block: widths, register
// indexes, CORDIC constants. No dependencies.
`default_nettype none
package ddo_pkg;
	localparam int CountBitsDefault = 32;
	localparam int CordicSteps = 24;
	localparam logic [1:0] RegMetres = 2'd0;
	localparam logic [1:0] RegTurn = 2'd1;
	localparam logic [1:0] RegInvert = 2'd2;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	typedef struct packed {
		logic signed [32:0] dsum;
		logic signed [32:0] ddif;
	} delta_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

/* src/ddo_if.sv */
// Valid/ready channel interfaces for the odometry block.
// Depends on nothing.
`default_nettype none
interface ddo_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;
	modport source (output valid, left_count, right_count, input ready);
	modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
	logic valid;
	logic ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic [31:0] heading_angle;
	logic signed [31:0] step_distance;
	logic signed [31:0] step_turn;
	modport source (output valid, pos_x, pos_y, heading_angle, step_distance, step_turn,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading_angle, step_distance, step_turn,
		output ready);
endinterface
`default_nettype wire

/* src/differential_drive_odometry.sv */
// Top level of the differential drive odometry block.
// Depends on ddo_pkg, ddo_if, ddo_front, ddo_back.
//
// Usage: the input channel carries absolute left and right encoder counts;
// the output channel returns one beat per input beat with position, heading
// and the step's distance and turn. Configuration registers are written by
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, as the block itself does not enforce it.
// Path from input beat to output valid: a queue pop, a multiply, 24 CORDIC
// iterations of one shared rotator, a product and an add.
// The back end takes a new delta only once the last one has left the output.
// A two-entry queue holds deltas so the front accepts while the back works.
// Reset clears counts, position and heading and loads the default scales.
// A stalled receiver holds the output beat; the queue then fills and input
// ready drops.
`default_nettype none
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int COUNT_BITS = CountBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	ddo_in_if.sink in_ch,
	ddo_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [23:0] cfg_data
);
	logic [23:0] metres_q, turn_q;
	logic invert_q;
	logic q_valid, q_pop;
	delta_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metres_q <= 24'd3267800;
			turn_q <= 24'd1368650;
			invert_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMetres: metres_q <= cfg_data;
				RegTurn: turn_q <= cfg_data;
				RegInvert: invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ddo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .invert(invert_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	ddo_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_data(q_data), .metres(metres_q), .turn(turn_q), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

/* src/ddo_front.sv */
// Front end: accepts count beats, forms wheel deltas, pushes a two-entry queue.
// Depends on ddo_pkg and ddo_if.
`default_nettype none
module ddo_front import ddo_pkg::*; #(
	parameter int COUNT_BITS = CountBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	ddo_in_if.sink in_ch,
	input wire logic invert,
	output logic q_valid,
	input wire logic q_pop,
	output delta_t q_data
);
	logic [COUNT_BITS-1:0] prev_l_q, prev_r_q, l_c, r_c, dl_u, dr_u;
	logic signed [32:0] dl, dr;
	delta_t ent_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign l_c = in_ch.left_count[COUNT_BITS-1:0];
	assign r_c = invert ? (COUNT_BITS'(0) - in_ch.right_count[COUNT_BITS-1:0])
		: in_ch.right_count[COUNT_BITS-1:0];
	assign dl_u = l_c - prev_l_q;
	assign dr_u = r_c - prev_r_q;
	assign dl = 33'(signed'(dl_u));
	assign dr = 33'(signed'(dr_u));
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				prev_l_q <= l_c;
				prev_r_q <= r_c;
				wr_q <= ~wr_q;
			end
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q].dsum <= dr + dl;
			ent_q[wr_q].ddif <= dr - dl;
		end
	end

`include "assert_macros.svh"
	`ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, q_pop, cnt_q != 2'd0)
	`ASSERT_IMPLIES(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`ASSERT_NEXT(a_push_fill, clk, arst_n, push && !q_pop && cnt_q == 2'd1, cnt_q == 2'd2)
endmodule
`default_nettype wire

/* src/ddo_back.sv */
// Back end: scale multiplies, CORDIC, position update and output register.
// Depends on ddo_pkg and ddo_if.
`default_nettype none
module ddo_back import ddo_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire delta_t q_data,
	input wire logic [23:0] metres,
	input wire logic [23:0] turn,
	ddo_out_if.source out_ch
);
	localparam logic [2:0] StIdle = 3'd0, StMul = 3'd1, StCord = 3'd2, StPos = 3'd3,
		StAdd = 3'd4, StOut = 3'd5;
	logic [2:0] st_q;
	logic [4:0] it_q;
	logic signed [32:0] half_q, ddif_q;
	logic signed [57:0] d40_q, t40_q;
	logic signed [31:0] sd_q, st32_q;
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic flip_q;
	logic signed [65:0] px_q, py_q;
	logic [47:0] posx_q, posy_q;
	logic [39:0] head_q;
	logic signed [57:0] d_sh, t_sh;
	logic signed [33:0] xs, ys, cx, cy;
	logic signed [32:0] z0, at;
	logic [31:0] ang;

	assign q_pop = (st_q == StIdle) && q_valid;
	assign out_ch.valid = (st_q == StOut);
	assign d_sh = d40_q >>> 16;
	assign t_sh = t40_q >>> 8;
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = 33'(atan_turn(it_q));
	assign ang = head_q[39:8];
	assign z0 = 33'(signed'(ang));
	assign cx = flip_q ? -x_q : x_q;
	assign cy = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			it_q <= '0;
			posx_q <= '0;
			posy_q <= '0;
			head_q <= '0;
		end else begin
			unique case (st_q)
				StIdle: if (q_valid) st_q <= StMul;
				StMul: begin
					st_q <= StCord;
					it_q <= '0;
				end
				StCord: begin
					if (it_q == 5'(CordicSteps - 1)) st_q <= StPos;
					it_q <= it_q + 5'd1;
				end
				StPos: st_q <= StAdd;
				StAdd: begin
					posx_q <= posx_q + 48'(px_q >>> 30);
					posy_q <= posy_q + 48'(py_q >>> 30);
					head_q <= head_q + t40_q[39:0];
					st_q <= StOut;
				end
				StOut: if (out_ch.ready) st_q <= StIdle;
				default: st_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			StIdle: begin
				half_q <= q_data.dsum / 2;
				ddif_q <= q_data.ddif;
			end
			StMul: begin
				d40_q <= 58'(half_q * signed'({1'b0, metres}));
				t40_q <= 58'(ddif_q * signed'({1'b0, turn}));
				x_q <= CordicGain;
				y_q <= '0;
				if (z0 > 33'sh40000000) begin
					z_q <= z0 - 33'sh80000000;
					flip_q <= 1'b1;
				end else if (z0 < -33'sh40000000) begin
					z_q <= z0 + 33'sh80000000;
					flip_q <= 1'b1;
				end else begin
					z_q <= z0;
					flip_q <= 1'b0;
				end
			end
			StCord: begin
				if (!z_q[32]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				sd_q <= (d_sh > 58'sh7FFFFFFF) ? 32'sh7FFFFFFF :
					(d_sh < -58'sh80000000) ? 32'sh80000000 : d_sh[31:0];
				st32_q <= (t_sh > 58'sh7FFFFFFF) ? 32'sh7FFFFFFF :
					(t_sh < -58'sh80000000) ? 32'sh80000000 : t_sh[31:0];
			end
			StPos: begin
				px_q <= 66'(sd_q * cx);
				py_q <= 66'(sd_q * cy);
			end
			default: ;
		endcase
	end

	assign out_ch.pos_x = signed'(posx_q);
	assign out_ch.pos_y = signed'(posy_q);
	assign out_ch.heading_angle = head_q[39:8];
	assign out_ch.step_distance = sd_q;
	assign out_ch.step_turn = st32_q;

`include "assert_macros.svh"
	`ASSERT_IMPLIES(a_pop_idle, clk, arst_n, q_pop, st_q == StIdle)
	`ASSERT_IMPLIES(a_it_range, clk, arst_n, st_q == StCord, it_q < 5'(CordicSteps))
	`ASSERT_NEXT(a_hold_out, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(posx_q))
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for differential_drive_odometry: a directed table, then random
// encoder sequences under several scale settings, checked against an in-bench predictor.
// Depends on ddo_pkg, ddo_if and differential_drive_odometry from the RTL.
`default_nettype none
module testbench;
	import ddo_pkg::*;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic [31:0] heading_angle;
		logic signed [31:0] step_distance;
		logic signed [31:0] step_turn;
	} odo_t;

	typedef struct {
		logic [31:0] left;
		logic [31:0] right;
		bit typed;
		odo_t known;
	} row_t;

	typedef struct {
		bit typed;
		odo_t known;
	} hint_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = RegMetres;
	logic [23:0] cfg_data = '0;

	ddo_in_if in_ch ();
	ddo_out_if out_ch ();

	differential_drive_odometry dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [23:0] metres_scale, turn_scale;
	bit invert;
	logic [31:0] last_left, last_right;
	logic [47:0] track_x, track_y;
	logic [39:0] heading_acc;

	odo_t pose_q[$];
	hint_t hint_q[$];
	int mismatches = 0;
	bit quiet = 0;
	int long_hold_req = 0;

	const longint atan_tbl[CordicSteps] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.left_count = '0;
		in_ch.right_count = '0;
		out_ch.ready = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void rotate_q30(input logic [31:0] ang, output longint c,
		output longint s);
		longint z, x, y, xs, ys;
		bit flip;
		z = longint'($signed(ang));
		x = longint'(CordicGain);
		y = 0;
		flip = 0;
		if (z > 64'sh40000000) begin
			z -= 64'sh80000000;
			flip = 1;
		end else if (z < -64'sh40000000) begin
			z += 64'sh80000000;
			flip = 1;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= atan_tbl[i];
			end else begin
				x += ys;
				y -= xs;
				z += atan_tbl[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic odo_t advance_pose(input logic [31:0] left, input logic [31:0] right);
		logic [31:0] r, dl32, dr32;
		longint dl, dr, half, d40, t40, sd, st, c, s, ms, ts;
		odo_t o;
		r = invert ? (32'd0 - right) : right;
		dl32 = left - last_left;
		dr32 = r - last_right;
		dl = longint'($signed(dl32));
		dr = longint'($signed(dr32));
		last_left = left;
		last_right = r;
		ms = longint'(metres_scale);
		ts = longint'(turn_scale);
		half = (dr + dl) / 2;
		d40 = half * ms;
		t40 = (dr - dl) * ts;
		sd = clamp32(d40 >>> 16);
		st = clamp32(t40 >>> 8);
		rotate_q30(heading_acc[39:8], c, s);
		track_x = track_x + 48'((sd * c) >>> 30);
		track_y = track_y + 48'((sd * s) >>> 30);
		heading_acc = heading_acc + 40'(t40);
		o.pos_x = track_x;
		o.pos_y = track_y;
		o.heading_angle = heading_acc[39:8];
		o.step_distance = 32'(sd);
		o.step_turn = 32'(st);
		return o;
	endfunction

	always @(posedge clk) begin
		hint_t h;
		odo_t p;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			p = advance_pose(in_ch.left_count, in_ch.right_count);
			h = hint_q.pop_front();
			pose_q.push_back(h.typed ? h.known : p);
		end
	end

	always @(posedge clk) begin
		odo_t e, a;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			a.pos_x = out_ch.pos_x;
			a.pos_y = out_ch.pos_y;
			a.heading_angle = out_ch.heading_angle;
			a.step_distance = out_ch.step_distance;
			a.step_turn = out_ch.step_turn;
			if (pose_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %p", a);
			end else begin
				e = pose_q.pop_front();
				if (e !== a) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", e, a);
				end
			end
		end
	end

	int stall_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (long_hold_req != 0) begin
			hold_left = long_hold_req;
			long_hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_counts(input logic [31:0] left, input logic [31:0] right,
		input bit typed, input odo_t known);
		hint_t h;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		h.typed = typed;
		h.known = known;
		hint_q.push_back(h);
		in_ch.valid <= 1'b1;
		in_ch.left_count <= left;
		in_ch.right_count <= right;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic load_scales(input logic [23:0] m, input logic [23:0] t, input bit inv);
		in_ch.valid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= RegMetres;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= RegTurn;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= RegInvert;
		cfg_data <= {23'd0, inv};
		@(posedge clk);
		cfg_we <= 1'b0;
		metres_scale = m;
		turn_scale = t;
		invert = inv;
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		odo_t zero;
		logic [31:0] cl, cr;
		logic [23:0] pm[6], pt[6];
		bit pi[6];
		arst_n <= 1'b0;
		zero = '0;
		metres_scale = 24'd3267800;
		turn_scale = 24'd1368650;
		invert = 1;
		last_left = '0;
		last_right = '0;
		track_x = '0;
		track_y = '0;
		heading_acc = '0;

		rows.push_back('{32'd0, 32'd0, 1, zero});
		rows.push_back('{32'd2, -32'sd2, 0, zero});
		rows.push_back('{32'd2, -32'sd2, 0, zero});
		rows.push_back('{32'h7FFFFFFF, 32'h80000000, 0, zero});
		rows.push_back('{32'h80000000, 32'h7FFFFFFF, 0, zero});
		rows.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 0, zero});
		rows.push_back('{32'd1, 32'd0, 0, zero});
		rows.push_back('{32'd0, 32'd1, 0, zero});
		for (int k = 1; k <= 8; k++)
			rows.push_back('{32'(k * 1000), 32'(-k * 1000 - k * 200000), 0, zero});
		rows.push_back('{32'h55555555, 32'hAAAAAAAA, 0, zero});
		rows.push_back('{32'hAAAAAAAA, 32'h55555555, 0, zero});
		rows.push_back('{32'h00000000, 32'h00000000, 0, zero});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_counts(rows[i].left, rows[i].right, rows[i].typed,
			rows[i].known);

		pm = '{24'd3267800, 24'hFFFFFF, 24'd0, 24'd1, 24'd0, 24'd0};
		pt = '{24'd1368650, 24'hFFFFFF, 24'd0, 24'd1, 24'd0, 24'd0};
		pi = '{1, 0, 1, 0, 0, 1};
		pm[4] = 24'($urandom);
		pt[4] = 24'($urandom);
		pm[5] = 24'($urandom_range(1000000, 5000000));
		pt[5] = 24'($urandom_range(500000, 3000000));
		cl = '0;
		cr = '0;
		for (int ph = 0; ph < 6; ph++) begin
			load_scales(pm[ph], pt[ph], pi[ph]);
			if (ph == 2) long_hold_req = 600;
			for (int n = 0; n < 210; n++) begin
				if (ph == 5 && n >= 60) quiet = 1;
				case ($urandom_range(0, 9))
					0: begin
						cl = $urandom;
						cr = $urandom;
					end
					1: begin
						cl += $urandom_range(0, 400000) - 200000;
						cr += $urandom_range(0, 400000) - 200000;
					end
					default: begin
						cl += $urandom_range(0, 4000) - 2000;
						cr += $urandom_range(0, 4000) - 2000;
					end
				endcase
				send_counts(cl, cr, 0, zero);
			end
		end
		in_ch.valid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && hint_q.size() == 0)
			$display("differential_drive_odometry verification clean");
		else
			$display("differential_drive_odometry verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("differential_drive_odometry verification failed");
		$finish;
	end
endmodule
`default_nettype wire

/* differential_drive_odometry.f */
+incdir+src
src/ddo_pkg.sv
src/ddo_if.sv
src/ddo_front.sv
src/ddo_back.sv
src/differential_drive_odometry.sv
tb/testbench.sv
